[rtl/core/hjc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hjc_pkg;
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam logic [31:0] COUNT_MAX = 32'hffffffff;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_PROBE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CMP, S_MUL, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_M = 2'd2,
        PH_X = 2'd3
    } t_phase;

    // golden offset and first finaliser xor-shift
    function automatic logic [63:0] mix_pre(input logic [63:0] x);
        logic [63:0] v;
        v = x + GOLDEN;
        return v ^ (v >> 30);
    endfunction
endpackage
`default_nettype wire

[rtl/core/hjc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface hjc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] key;
    modport source (output valid, output command, output key, input ready);
    modport sink (input valid, input command, input key, output ready);
endinterface
`default_nettype wire

[rtl/core/hjc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface hjc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] multiplicity;
    logic [63:0] join_total;
    logic [63:0] checksum_one;
    logic [63:0] checksum_two;
    logic        table_full;
    modport source (output valid, output multiplicity, output join_total,
                    output checksum_one, output checksum_two, output table_full,
                    input ready);
    modport sink (input valid, input multiplicity, input join_total,
                  input checksum_one, input checksum_two, input table_full,
                  output ready);
endinterface
`default_nettype wire

[rtl/core/hash_join_count_checksum.sv]
`timescale 1ns / 1ps
`default_nettype none
// hash join count and checksum engine
// i_in carries one command beat (clear, build key, probe key); o_out returns
// exactly one result beat per command: multiplicity, the three running totals
// and the table-full flag.
// keys and counts live in one synchronous memory that is scanned linearly, one
// entry at a time (read, then compare), over the entries in use.
// clear and the unused command go from idle straight to the done state.
// build and probe compare entries in turn until a hit or the end.
// a probe hit then runs two splitmix finalisers: they and their products with the
// count run on one 32x32 multiplier, three passes per 64-bit product, nine per
// checksum.
// one item at a time; the next beat is taken once the current one has moved to
// the output register, so a result waiting on a stalled receiver does not block
// the input; a second result waits internally until the first is taken.
// reset empties the table (fill count to zero) and zeroes the totals; clear
// does the same at run time, with no sweep of the memory.
module hash_join_count_checksum (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hjc_in_if.sink     i_in,
    hjc_out_if.source  o_out
);
    hjc_pkg::t_state r_state, n_state;
    logic [1:0]  r_cmd;
    logic [63:0] r_key;
    logic [hjc_pkg::CNT_W-1:0] r_idx, n_idx, r_used, n_used;
    logic [31:0] r_mult, n_mult;
    logic        r_full, n_full;
    logic [63:0] r_pair, n_pair, r_sum1, n_sum1, r_sum2, n_sum2;
    logic [63:0] r_ma, n_ma, r_acc, n_acc;
    hjc_pkg::t_phase r_ph, n_ph;
    logic [1:0]  r_step, n_step;
    logic        r_hsel, n_hsel;
    logic        r_ov;
    logic        take;

    logic [95:0] mem [hjc_pkg::TABLE_ENTRIES];
    logic [95:0] r_rd;
    logic        we;
    logic [hjc_pkg::IDX_W-1:0] waddr;
    logic [95:0] wdata;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[r_idx[hjc_pkg::IDX_W-1:0]];
    end

    // multiplier operands for the current pass
    logic [63:0] mb, prod, fin;
    logic [31:0] pa, pb;
    always_comb begin
        unique case (r_ph)
            hjc_pkg::PH_A: mb = hjc_pkg::MIX_MUL_A;
            hjc_pkg::PH_B: mb = hjc_pkg::MIX_MUL_B;
            default:       mb = {32'd0, r_mult};
        endcase
        unique case (r_step)
            2'd0:    begin pa = r_ma[31:0];  pb = mb[31:0];  end
            2'd1:    begin pa = r_ma[31:0];  pb = mb[63:32]; end
            default: begin pa = r_ma[63:32]; pb = mb[31:0];  end
        endcase
        prod = {32'd0, pa} * {32'd0, pb};
        if (r_step == 2'd0) begin
            fin = prod;
        end else begin
            fin = r_acc + {prod[31:0], 32'd0};
        end
    end

    logic [31:0] rd_cnt, inc_cnt;
    assign rd_cnt  = r_rd[31:0];
    assign inc_cnt = (rd_cnt == hjc_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 32'd1;
    assign take    = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == hjc_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;  n_used = r_used;
        n_mult = r_mult; n_full = r_full;
        n_pair = r_pair; n_sum1 = r_sum1; n_sum2 = r_sum2;
        n_ma = r_ma; n_acc = r_acc; n_ph = r_ph; n_step = r_step; n_hsel = r_hsel;
        we = 1'b0;
        waddr = r_idx[hjc_pkg::IDX_W-1:0];
        wdata = {r_key, 32'd1};
        unique case (r_state)
            hjc_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_idx = '0;
                    n_mult = '0;
                    n_full = 1'b0;
                    unique case (hjc_pkg::t_cmd'(i_in.command))
                        hjc_pkg::CMD_CLEAR: begin
                            n_used = '0;
                            n_pair = '0; n_sum1 = '0; n_sum2 = '0;
                            n_state = hjc_pkg::S_DONE;
                        end
                        hjc_pkg::CMD_BUILD, hjc_pkg::CMD_PROBE: n_state = hjc_pkg::S_RD;
                        default: n_state = hjc_pkg::S_DONE;
                    endcase
                end
            end
            hjc_pkg::S_RD: begin
                if (r_idx < r_used) begin
                    n_state = hjc_pkg::S_CMP;
                end else begin
                    // miss: a build claims the next free entry if there is one, else flags the table full
                    if (hjc_pkg::t_cmd'(r_cmd) == hjc_pkg::CMD_BUILD) begin
                        if (r_used < hjc_pkg::CNT_W'(hjc_pkg::TABLE_ENTRIES)) begin
                            we = 1'b1;
                            waddr = r_used[hjc_pkg::IDX_W-1:0];
                            n_used = r_used + 1'b1;
                            n_mult = 32'd1;
                        end else begin
                            n_full = 1'b1;
                        end
                    end
                    n_state = hjc_pkg::S_DONE;
                end
            end
            hjc_pkg::S_CMP: begin
                if (r_rd[95:32] == r_key) begin
                    if (hjc_pkg::t_cmd'(r_cmd) == hjc_pkg::CMD_BUILD) begin
                        we = 1'b1;
                        wdata = {r_key, inc_cnt};
                        n_mult = inc_cnt;
                        n_state = hjc_pkg::S_DONE;
                    end else begin
                        n_mult = rd_cnt;
                        n_pair = r_pair + {32'd0, rd_cnt};
                        n_ma = hjc_pkg::mix_pre(r_key);
                        n_ph = hjc_pkg::PH_A; n_step = 2'd0; n_hsel = 1'b0;
                        n_state = hjc_pkg::S_MUL;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = hjc_pkg::S_RD;
                end
            end
            hjc_pkg::S_MUL: begin
                n_acc = fin;
                n_step = r_step + 2'd1;
                if (r_step == 2'd2) begin
                    n_step = 2'd0;
                    unique case (r_ph)
                        hjc_pkg::PH_A: begin
                            n_ma = fin ^ (fin >> 27);
                            n_ph = hjc_pkg::PH_B;
                        end
                        hjc_pkg::PH_B: begin
                            n_ma = fin ^ (fin >> 31);
                            n_ph = hjc_pkg::PH_M;
                        end
                        default: begin
                            n_ph = hjc_pkg::PH_A;
                            if (!r_hsel) begin
                                n_sum1 = r_sum1 + fin;
                                n_hsel = 1'b1;
                                n_ma = hjc_pkg::mix_pre(r_key ^ hjc_pkg::GOLDEN);
                            end else begin
                                n_sum2 = r_sum2 + fin;
                                n_state = hjc_pkg::S_DONE;
                            end
                        end
                    endcase
                end
            end
            default: begin
                if (take) begin
                    n_state = hjc_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hjc_pkg::S_IDLE;
            r_used <= '0;
            r_pair <= '0; r_sum1 <= '0; r_sum2 <= '0;
            r_ov <= 1'b0;
            r_ph <= hjc_pkg::PH_A;
            r_step <= 2'd0;
            r_hsel <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used <= n_used;
            r_pair <= n_pair; r_sum1 <= n_sum1; r_sum2 <= n_sum2;
            r_ph <= n_ph; r_step <= n_step; r_hsel <= n_hsel;
            if (r_state == hjc_pkg::S_DONE && take) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd <= i_in.command;
            r_key <= i_in.key;
        end
        r_idx <= n_idx; r_mult <= n_mult; r_full <= n_full;
        r_ma <= n_ma; r_acc <= n_acc;
        if (r_state == hjc_pkg::S_DONE && take) begin
            o_out.multiplicity <= r_mult;
            o_out.join_total   <= r_pair;
            o_out.checksum_one <= r_sum1;
            o_out.checksum_two <= r_sum2;
            o_out.table_full   <= r_full;
        end
    end
    assign o_out.valid = r_ov;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= hjc_pkg::CNT_W'(hjc_pkg::TABLE_ENTRIES))
        else $error("fill count beyond table size");
    a_full_no_mult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hjc_pkg::S_DONE && r_full) |-> (r_mult == 32'd0))
        else $error("dropped key with nonzero multiplicity");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != hjc_pkg::S_IDLE))
        else $error("accepted beat not processed");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hjc_pkg::S_MUL) |-> (r_step != 2'd3 && r_ph != hjc_pkg::PH_X))
        else $error("multiplier sequencer out of range");
`endif
endmodule
`default_nettype wire
